FILE: rtl/core/flha_pkg.sv
// -----------------------------------------------------------------------------
// flha_pkg: shared types and constants of the free-list heap allocator
// request and response field widths, operation and status codes, and the
// header store enable group
// -----------------------------------------------------------------------------
package flha_pkg;

	localparam int unsigned BYTES_W   = 16;
	localparam int unsigned ADDR_W    = 6;
	// wide enough for any rounded unit count and any block size
	localparam int unsigned CMP_W     = 17;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_NOMEM = 1'b1
	} status_t;

	// header store port controls
	typedef struct packed {
		logic rd;
		logic wr_next;
		logic wr_size;
	} hdr_en_t;

endpackage

FILE: rtl/core/flha_if.sv
// -----------------------------------------------------------------------------
// flha_if: request and response channels
// valid/ready channels, a transfer happens when valid and ready are both high
// -----------------------------------------------------------------------------
interface flha_req_if;
	logic                           valid;
	logic                           ready;
	flha_pkg::opcode_t              opcode;
	logic [flha_pkg::BYTES_W-1:0]   request_bytes;
	logic [flha_pkg::ADDR_W-1:0]    block_address;

	modport source (output valid, opcode, request_bytes, block_address, input ready);
	modport sink (input valid, opcode, request_bytes, block_address, output ready);
endinterface

interface flha_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [flha_pkg::ADDR_W-1:0]    payload_address;
	flha_pkg::status_t              status;

	modport source (output valid, payload_address, status, input ready);
	modport sink (input valid, payload_address, status, output ready);
endinterface

FILE: rtl/core/flha_hdr_mem.sv
// -----------------------------------------------------------------------------
// flha_hdr_mem: block header store
// next link and size per unit, one read and one write address per cycle,
// registered read data
// -----------------------------------------------------------------------------
module flha_hdr_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IW    = 6,
	parameter int unsigned SW    = 7
) (
	input  logic              clk,
	input  flha_pkg::hdr_en_t en,
	input  logic [IW-1:0]     rd_addr,
	input  logic [IW-1:0]     wr_addr,
	input  logic [IW-1:0]     wd_next,
	input  logic [SW-1:0]     wd_size,
	output logic [IW-1:0]     rd_next,
	output logic [SW-1:0]     rd_size
);

	logic [IW-1:0] next_mem [DEPTH];
	logic [SW-1:0] size_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en.wr_next) begin
			next_mem[wr_addr] <= wd_next;
		end
		if (en.wr_size) begin
			size_mem[wr_addr] <= wd_size;
		end
		if (en.rd) begin
			rd_next <= next_mem[rd_addr];
			rd_size <= size_mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/free_list_heap_allocator.sv
// -----------------------------------------------------------------------------
// free_list_heap_allocator: next-fit free-list heap allocator
// address-ordered circular free list with roving pointer, tail carving on
// allocate and neighbor coalescing on free
// -----------------------------------------------------------------------------
// The arena holds ARENA_UNITS header-sized units of UNIT_BYTES bytes. An
// allocate takes ceil(request_bytes / UNIT_BYTES) + 1 units and returns the
// payload unit index (header + 1), or status out-of-memory with index zero;
// the arena becomes one free block on the first allocate. A free links the
// block back in address order and merges it with free neighbors; a free of
// index zero, beyond the arena or before the first allocate is ignored, and
// other bad indices are not checked. One request is handled at a time and
// the request side is ready only while idle. Every step of a list walk reads
// one header from the header store, which has one read and one write port;
// a walk visits at most ARENA_UNITS + 1 free blocks. An allocate that
// carves a tail passes through an extra carve state, and an ignored free,
// a free into an empty list or an allocate on an empty list does no walk.
// A finished response waits in an output register, so the next request may
// be taken while it is still pending.
// There is no clearing pass: headers are written before they are read.
// -----------------------------------------------------------------------------
module free_list_heap_allocator #(
	parameter int unsigned ARENA_UNITS = 64,
	parameter int unsigned UNIT_BYTES  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	flha_req_if.sink       req,
	flha_rsp_if.source     rsp
);

	// index and size widths
	localparam int unsigned IW     = $clog2(ARENA_UNITS);
	localparam int unsigned SW     = $clog2(2 * ARENA_UNITS);
	localparam int unsigned STEP_W = $clog2(ARENA_UNITS + 1);
	localparam int unsigned CW     = flha_pkg::CMP_W;
	localparam int unsigned AW     = flha_pkg::ADDR_W;

	localparam logic [SW-1:0]     SIZE_MASK = SW'(2 * ARENA_UNITS - 1);
	localparam logic [SW-1:0]     ARENA_SZ  = SW'(ARENA_UNITS) & SIZE_MASK;
	// last walk step, the walk visits at most ARENA_UNITS + 1 blocks
	localparam logic [STEP_W-1:0] WALK_LAST = STEP_W'(ARENA_UNITS);

	// byte count to units: exact reciprocal multiply for a 17-bit dividend
	localparam int unsigned NUM_W     = flha_pkg::BYTES_W + 1;
	localparam int unsigned DIV_L     = $clog2(UNIT_BYTES);
	localparam int unsigned DIV_SHIFT = NUM_W + DIV_L;
	localparam int unsigned DIV_MUL_W = NUM_W + 1;
	localparam int unsigned DIV_MUL   = ((1 << DIV_SHIFT) + UNIT_BYTES - 1) / UNIT_BYTES;
	localparam int unsigned PROD_W    = NUM_W + DIV_MUL_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_DIV,
		S_A_NEED,
		S_A_FIRST,
		S_A_CHK,
		S_A_CARVE,
		S_F_START,
		S_F_WALK,
		S_F_GETP,
		S_F_GETBP,
		S_F_HI,
		S_F_LO,
		S_DONE
	} state_t;

	state_t                    state_q;

	// allocator state
	logic [IW-1:0]             rover_q;
	logic                      started_q;
	logic                      empty_q;

	// per-request working registers
	logic [flha_pkg::BYTES_W-1:0] bytes_q;
	logic [AW-1:0]             addr_q;
	logic [IW-1:0]             bp_q;
	logic [PROD_W-1:0]         prod_q;
	logic [CW-1:0]             need_q;
	logic [IW-1:0]             prev_q;
	logic [IW-1:0]             p_q;
	logic [STEP_W-1:0]         steps_q;
	logic [SW-1:0]             p_size_q;
	logic [IW-1:0]             nx_q;
	logic [SW-1:0]             bp_size_q;
	logic [SW-1:0]             bpn_size_q;
	logic [IW-1:0]             bpn_next_q;

	// finished result and output register
	logic [AW-1:0]             res_addr_q;
	flha_pkg::status_t         res_status_q;
	logic                      rsp_valid_q;
	logic [AW-1:0]             rsp_addr_q;
	flha_pkg::status_t         rsp_status_q;

	// header store port
	flha_pkg::hdr_en_t         hdr_en;
	logic [IW-1:0]             hdr_rd_addr;
	logic [IW-1:0]             hdr_wr_addr;
	logic [IW-1:0]             hdr_wd_next;
	logic [SW-1:0]             hdr_wd_size;
	logic [IW-1:0]             hdr_rd_next;
	logic [SW-1:0]             hdr_rd_size;

	// decisions shared by the port control and the sequencer
	logic [NUM_W-1:0]          div_num;
	logic                      fit;
	logic                      exact;
	logic [SW-1:0]             carve_size;
	logic [IW-1:0]             carve_at;
	logic                      free_ok;
	logic                      walk_brk;
	logic [SW:0]               hi_end;
	logic                      merge_hi;
	logic [SW-1:0]             hi_size;
	logic [SW-1:0]             p_size_eff;
	logic [SW:0]               lo_end;
	logic                      merge_lo;
	logic [SW-1:0]             lo_size;

	// reduce an index sum below 3 * ARENA_UNITS into the arena
	function automatic logic [IW-1:0] wrap_idx(input logic [SW:0] x);
		logic [SW:0] t;
		t = x;
		if (t >= (SW+1)'(2 * ARENA_UNITS)) begin
			t = t - (SW+1)'(2 * ARENA_UNITS);
		end else if (t >= (SW+1)'(ARENA_UNITS)) begin
			t = t - (SW+1)'(ARENA_UNITS);
		end
		return IW'(t);
	endfunction

	// payload index is header + 1, masked to the field width
	function automatic logic [AW-1:0] payload_of(input logic [IW-1:0] h);
		return AW'(32'(h) + 32'd1);
	endfunction

	flha_hdr_mem #(
		.DEPTH (ARENA_UNITS),
		.IW    (IW),
		.SW    (SW)
	) u_hdr_mem (
		.clk     (clk),
		.en      (hdr_en),
		.rd_addr (hdr_rd_addr),
		.wr_addr (hdr_wr_addr),
		.wd_next (hdr_wd_next),
		.wd_size (hdr_wd_size),
		.rd_next (hdr_rd_next),
		.rd_size (hdr_rd_size)
	);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.payload_address = rsp_addr_q;
	assign rsp.status      = rsp_status_q;

	// shared compare / add unit
	always_comb begin
		div_num    = NUM_W'(bytes_q) + NUM_W'(UNIT_BYTES - 1);
		// allocate: does the block at p hold the request
		fit        = (CW'(hdr_rd_size) >= need_q);
		exact      = (CW'(hdr_rd_size) == need_q);
		carve_size = SW'(CW'(hdr_rd_size) - need_q) & SIZE_MASK;
		carve_at   = wrap_idx((SW+1)'(p_q) + (SW+1)'(carve_size));
		// free: index in range and arena set up
		free_ok    = started_q && (addr_q != '0)
			&& ((32'(addr_q) - 32'd1) < ARENA_UNITS);
		// free: bp falls between p and its successor, or past the wrap point
		walk_brk   = ((bp_q > p_q) && (bp_q < hdr_rd_next))
			|| ((p_q >= hdr_rd_next) && ((bp_q > p_q) || (bp_q < hdr_rd_next)));
		// free: upper neighbor, header of nx on the read port
		hi_end     = (SW+1)'(bp_q) + (SW+1)'(bp_size_q);
		merge_hi   = (hi_end == (SW+1)'(nx_q));
		hi_size    = SW'((SW+1)'(bp_size_q) + (SW+1)'(hdr_rd_size)) & SIZE_MASK;
		// free: lower neighbor, sees the bp header as just rewritten
		p_size_eff = (p_q == bp_q) ? bpn_size_q : p_size_q;
		lo_end     = (SW+1)'(p_q) + (SW+1)'(p_size_eff);
		merge_lo   = (lo_end == (SW+1)'(bp_q));
		lo_size    = SW'((SW+1)'(p_size_eff) + (SW+1)'(bpn_size_q)) & SIZE_MASK;
	end

	// header store port control
	always_comb begin
		hdr_en      = '0;
		hdr_rd_addr = '0;
		hdr_wr_addr = '0;
		hdr_wd_next = '0;
		hdr_wd_size = '0;
		case (state_q)
			S_A_DIV: begin
				// lazy start: whole arena as one self-linked block at unit 0
				if (!started_q) begin
					hdr_en.wr_next = 1'b1;
					hdr_en.wr_size = 1'b1;
					hdr_wd_size    = ARENA_SZ;
				end
			end
			S_A_NEED: begin
				hdr_en.rd   = !empty_q;
				hdr_rd_addr = rover_q;
			end
			S_A_FIRST: begin
				hdr_en.rd   = 1'b1;
				hdr_rd_addr = hdr_rd_next;
			end
			S_A_CHK: begin
				if (fit) begin
					if (!exact) begin
						// carve from the tail: shrink p first
						hdr_en.wr_size = 1'b1;
						hdr_wr_addr    = p_q;
						hdr_wd_size    = carve_size;
					end else if (p_q != prev_q) begin
						// unlink p
						hdr_en.wr_next = 1'b1;
						hdr_wr_addr    = prev_q;
						hdr_wd_next    = hdr_rd_next;
					end
				end else if ((p_q != rover_q) && (steps_q != WALK_LAST)) begin
					hdr_en.rd   = 1'b1;
					hdr_rd_addr = hdr_rd_next;
				end
			end
			S_A_CARVE: begin
				hdr_en.wr_size = 1'b1;
				hdr_wr_addr    = p_q;
				hdr_wd_size    = SW'(need_q) & SIZE_MASK;
			end
			S_F_START: begin
				if (free_ok && empty_q) begin
					hdr_en.wr_next = 1'b1;
					hdr_wr_addr    = bp_q;
					hdr_wd_next    = bp_q;
				end else if (free_ok) begin
					hdr_en.rd   = 1'b1;
					hdr_rd_addr = rover_q;
				end
			end
			S_F_WALK: begin
				// on a break re-read p, else fetch the successor
				hdr_en.rd   = 1'b1;
				hdr_rd_addr = walk_brk ? p_q : hdr_rd_next;
			end
			S_F_GETP: begin
				hdr_en.rd   = 1'b1;
				hdr_rd_addr = bp_q;
			end
			S_F_GETBP: begin
				hdr_en.rd   = 1'b1;
				hdr_rd_addr = nx_q;
			end
			S_F_HI: begin
				hdr_en.wr_next = 1'b1;
				hdr_en.wr_size = merge_hi;
				hdr_wr_addr    = bp_q;
				hdr_wd_next    = merge_hi ? hdr_rd_next : nx_q;
				hdr_wd_size    = hi_size;
			end
			S_F_LO: begin
				hdr_en.wr_next = 1'b1;
				hdr_en.wr_size = merge_lo;
				hdr_wr_addr    = p_q;
				hdr_wd_next    = merge_lo ? bpn_next_q : bp_q;
				hdr_wd_size    = lo_size;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rover_q      <= '0;
			started_q    <= 1'b0;
			empty_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// response transfer frees the output register, unless S_DONE refills it
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						bytes_q <= req.request_bytes;
						addr_q  <= req.block_address;
						bp_q    <= IW'(32'(req.block_address) - 32'd1);
						state_q <= (req.opcode == flha_pkg::OP_FREE) ? S_F_START : S_A_DIV;
					end
				end
				S_A_DIV: begin
					prod_q <= PROD_W'(div_num) * PROD_W'(DIV_MUL);
					if (!started_q) begin
						rover_q   <= '0;
						started_q <= 1'b1;
						empty_q   <= 1'b0;
					end
					state_q <= S_A_NEED;
				end
				S_A_NEED: begin
					need_q <= CW'(prod_q[PROD_W-1:DIV_SHIFT]) + CW'(1);
					prev_q <= rover_q;
					if (empty_q) begin
						res_addr_q   <= '0;
						res_status_q <= flha_pkg::STATUS_NOMEM;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_A_FIRST;
					end
				end
				S_A_FIRST: begin
					p_q     <= hdr_rd_next;
					steps_q <= '0;
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (fit) begin
						if (exact) begin
							// last free block taken whole empties the list
							if (p_q == prev_q) begin
								empty_q <= 1'b1;
							end
							rover_q      <= prev_q;
							res_addr_q   <= payload_of(p_q);
							res_status_q <= flha_pkg::STATUS_OK;
							state_q      <= S_DONE;
						end else begin
							p_q     <= carve_at;
							state_q <= S_A_CARVE;
						end
					end else if ((p_q == rover_q) || (steps_q == WALK_LAST)) begin
						// wrapped around, or list too long
						res_addr_q   <= '0;
						res_status_q <= flha_pkg::STATUS_NOMEM;
						state_q      <= S_DONE;
					end else begin
						prev_q  <= p_q;
						p_q     <= hdr_rd_next;
						steps_q <= steps_q + STEP_W'(1);
					end
				end
				S_A_CARVE: begin
					rover_q      <= prev_q;
					res_addr_q   <= payload_of(p_q);
					res_status_q <= flha_pkg::STATUS_OK;
					state_q      <= S_DONE;
				end
				S_F_START: begin
					res_addr_q   <= '0;
					res_status_q <= flha_pkg::STATUS_OK;
					if (!free_ok) begin
						state_q <= S_DONE;
					end else if (empty_q) begin
						// freed block becomes the only entry
						rover_q <= bp_q;
						empty_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						p_q     <= rover_q;
						steps_q <= '0;
						state_q <= S_F_WALK;
					end
				end
				S_F_WALK: begin
					if (walk_brk) begin
						state_q <= S_F_GETP;
					end else begin
						p_q <= hdr_rd_next;
						if (steps_q == WALK_LAST) begin
							state_q <= S_F_GETP;
						end else begin
							steps_q <= steps_q + STEP_W'(1);
						end
					end
				end
				S_F_GETP: begin
					p_size_q <= hdr_rd_size;
					nx_q     <= hdr_rd_next;
					state_q  <= S_F_GETBP;
				end
				S_F_GETBP: begin
					bp_size_q <= hdr_rd_size;
					state_q   <= S_F_HI;
				end
				S_F_HI: begin
					// keep bp header as written for the lower merge
					bpn_size_q <= merge_hi ? hi_size : bp_size_q;
					bpn_next_q <= merge_hi ? hdr_rd_next : nx_q;
					state_q    <= S_F_LO;
				end
				S_F_LO: begin
					rover_q <= p_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_addr_q   <= res_addr_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an empty list only exists once the arena has been set up
	a_empty_started: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> started_q)
		else $error("free list empty before arena start");

	// rover always names a unit inside the arena
	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (32'(rover_q) < ARENA_UNITS))
		else $error("rover outside arena");

	// out of memory always reports payload index zero
	a_nomem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == flha_pkg::STATUS_NOMEM)) |-> (rsp_addr_q == '0))
		else $error("failed allocate with nonzero payload");

	// headers change only while a request is being worked
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) || (state_q == S_DONE)) |-> !(hdr_en.wr_next || hdr_en.wr_size))
		else $error("header write outside a request");

endmodule
